@@ src/npucs_pkg.sv @@
// Shared types, command codes and sizing constants for the NPU command sequencer.
// Used by the front decoder, the command queue, the execute unit and the top level.
// No dependencies.
package npucs_pkg;

	localparam int NUM_REGS      = 32;
	localparam int REG_BASE      = 2;
	localparam int PROGRAM_DEPTH = 1024;
	localparam int VALUE_WIDTH   = 16;
	localparam int PC_WIDTH      = 11;
	localparam int REG_IDX_WIDTH = 5;
	localparam int RAW_IDX_WIDTH = 6;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] CMD_NOP       = 4'd0;
	localparam logic [3:0] CMD_SYNC      = 4'd1;
	localparam logic [3:0] CMD_INTR      = 4'd2;
	localparam logic [3:0] CMD_CONV      = 4'd3;
	localparam logic [3:0] CMD_LOOPCOUNT = 4'd4;
	localparam logic [3:0] CMD_LOOP      = 4'd5;
	localparam logic [3:0] CMD_REGWRITE  = 4'd6;
	localparam logic [3:0] CMD_REGINC    = 4'd7;
	localparam logic [3:0] CMD_RESTART   = 4'd8;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SYNC,
		OP_INTR,
		OP_CONV,
		OP_LOAD_COUNT,
		OP_LOOP,
		OP_REG_WRITE,
		OP_REG_INC,
		OP_RESTART,
		OP_REG_BAD
	} op_t;

	typedef struct packed {
		logic [3:0]  command;
		logic [5:0]  reg_index;
		logic [15:0] reg_value;
		logic [15:0] loop_total;
		logic [10:0] jump_offset;
		logic [7:0]  intr_code;
	} cmd_item_t;

	typedef struct packed {
		logic [10:0] next_pc;
		logic        write_valid;
		logic [4:0]  write_index;
		logic [15:0] write_data;
		logic        conv_start;
		logic        intr_valid;
		logic [7:0]  intr_latched;
		logic        halted;
		logic        program_done;
		logic        fault;
	} result_item_t;

	// Decoded command as it sits in the queue. The argument is the register
	// value for register commands and the loop total for a loop count load.
	typedef struct packed {
		op_t                      op;
		logic [REG_IDX_WIDTH-1:0] reg_num;
		logic [VALUE_WIDTH-1:0]   arg;
		logic [PC_WIDTH-1:0]      offset;
		logic [7:0]               code;
	} op_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

@@ src/npu_command_sequencer.sv @@
// Top level of the NPU command sequencer.
// Instantiates npucs_front, npucs_queue and npucs_exec; depends on npucs_pkg.
//
// Usage: the fetch side presents one command per transaction on in_valid/in_data
// and holds it while in_stall is high. Each command yields exactly one result
// transaction on out_valid/out_data, in order: next program counter, shadow
// register write, conv start, interrupt latch, halt, program done and fault.
// program_length is loaded through cfg_we/cfg_wdata; the user must load it only while no
// command is in flight, as the block does not enforce it. The front end decodes a command
// combinationally into a two-entry queue at the accepting edge, and the execute unit then
// retires it into the output register. Throughput is one command per cycle while the
// receiver does not stall, as pc, loop counter and shadow register update together.
// When the receiver stalls the result holds in the output register, the queue
// fills, and in_stall rises once both queue entries are occupied.
// Reset clears pc, loop counter, all shadow registers, the interrupt latch,
// program_length and the queue; no clearing pass is needed afterward.
module npu_command_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [npucs_pkg::PC_WIDTH-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  npucs_pkg::cmd_item_t           in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output npucs_pkg::result_item_t        out_data
);

	npucs_pkg::op_item_t      dec_item;
	npucs_pkg::op_item_t      q_item;
	npucs_pkg::queue_status_t q_status;
	logic                     q_push;
	logic                     q_pop;

	assign in_stall = q_status.full;
	assign q_push   = in_valid && !q_status.full;

	npucs_front u_front (
		.in_data (in_data),
		.op_item (dec_item)
	);

	npucs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (dec_item),
		.pop       (q_pop),
		.pop_data  (q_item),
		.status    (q_status)
	);

	npucs_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_item   (q_item),
		.q_status  (q_status),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// The execute unit must never retire from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("execute unit popped an empty queue");

	// With nothing queued, a delivered result leaves the output register empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && q_status.empty) |=> !out_valid)
		else $error("result appeared without a queued command");

	// The program counter saturates at the program depth.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.next_pc <= npucs_pkg::PC_WIDTH'(npucs_pkg::PROGRAM_DEPTH)))
		else $error("next_pc beyond program depth");

	// A faulting command never writes a shadow register.
	a_fault_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.op == npucs_pkg::OP_REG_BAD) |=> (out_data.fault && !out_data.write_valid))
		else $error("bad register index produced a write");

endmodule

@@ src/npucs_front.sv @@
// Front end of the NPU command sequencer: takes commands and classifies them.
// Checks the register index and packs a decoded op for the command queue.
// Depends on npucs_pkg.
module npucs_front (
	input  npucs_pkg::cmd_item_t     in_data,
	output npucs_pkg::op_item_t      op_item
);

	logic [npucs_pkg::RAW_IDX_WIDTH-1:0] raw_off;
	logic                                idx_ok;

	assign raw_off = in_data.reg_index - npucs_pkg::RAW_IDX_WIDTH'(npucs_pkg::REG_BASE);
	assign idx_ok  = (in_data.reg_index >= npucs_pkg::RAW_IDX_WIDTH'(npucs_pkg::REG_BASE)) &&
	                 (raw_off < npucs_pkg::RAW_IDX_WIDTH'(npucs_pkg::NUM_REGS));

	always_comb begin
		op_item.reg_num = raw_off[npucs_pkg::REG_IDX_WIDTH-1:0];
		op_item.offset  = in_data.jump_offset;
		op_item.code    = in_data.intr_code;
		op_item.arg     = in_data.loop_total;
		case (in_data.command)
			npucs_pkg::CMD_SYNC:      op_item.op = npucs_pkg::OP_SYNC;
			npucs_pkg::CMD_INTR:      op_item.op = npucs_pkg::OP_INTR;
			npucs_pkg::CMD_CONV:      op_item.op = npucs_pkg::OP_CONV;
			npucs_pkg::CMD_LOOPCOUNT: op_item.op = npucs_pkg::OP_LOAD_COUNT;
			npucs_pkg::CMD_LOOP:      op_item.op = npucs_pkg::OP_LOOP;
			npucs_pkg::CMD_REGWRITE: begin
				op_item.arg = in_data.reg_value;
				op_item.op  = idx_ok ? npucs_pkg::OP_REG_WRITE : npucs_pkg::OP_REG_BAD;
			end
			npucs_pkg::CMD_REGINC: begin
				op_item.arg = in_data.reg_value;
				op_item.op  = idx_ok ? npucs_pkg::OP_REG_INC : npucs_pkg::OP_REG_BAD;
			end
			npucs_pkg::CMD_RESTART:   op_item.op = npucs_pkg::OP_RESTART;
			default:                  op_item.op = npucs_pkg::OP_NOP;
		endcase
	end

endmodule

@@ src/npucs_queue.sv @@
// Short queue of decoded commands between the front end and the execute unit.
// Registered full and empty flags so neither side sees the other combinationally.
// Depends on npucs_pkg.
module npucs_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  npucs_pkg::op_item_t       push_data,
	input  logic                      pop,
	output npucs_pkg::op_item_t       pop_data,
	output npucs_pkg::queue_status_t  status
);

	npucs_pkg::op_item_t                 entry_q [npucs_pkg::QUEUE_DEPTH];
	logic [npucs_pkg::QPTR_WIDTH-1:0]    wr_ptr_q;
	logic [npucs_pkg::QPTR_WIDTH-1:0]    rd_ptr_q;
	logic [npucs_pkg::QCNT_WIDTH-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data     = entry_q[rd_ptr_q];
	assign status.full  = (count_q == npucs_pkg::QCNT_WIDTH'(npucs_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

@@ src/npucs_exec.sv @@
// Execute unit of the NPU command sequencer: program counter, loop counter,
// shadow register file, interrupt latch and the registered result stage.
// Depends on npucs_pkg.
module npucs_exec (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [npucs_pkg::PC_WIDTH-1:0] cfg_wdata,
	input  npucs_pkg::op_item_t            op_item,
	input  npucs_pkg::queue_status_t       q_status,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output npucs_pkg::result_item_t        out_data
);

	localparam logic [npucs_pkg::PC_WIDTH-1:0] PcMax =
		npucs_pkg::PC_WIDTH'(npucs_pkg::PROGRAM_DEPTH);

	logic [npucs_pkg::PC_WIDTH-1:0]    pc_q;
	logic [npucs_pkg::PC_WIDTH-1:0]    plen_q;
	logic [npucs_pkg::VALUE_WIDTH-1:0] loop_q;
	logic [7:0]                        intr_q;
	logic [npucs_pkg::VALUE_WIDTH-1:0] shadow_q [npucs_pkg::NUM_REGS];
	logic                              out_valid_q;
	npucs_pkg::result_item_t           out_q;

	logic [npucs_pkg::PC_WIDTH-1:0]    pc_inc;
	logic signed [npucs_pkg::PC_WIDTH+1:0] target;
	logic [npucs_pkg::VALUE_WIDTH-1:0] reg_sum;
	logic [npucs_pkg::PC_WIDTH-1:0]    next_pc;
	logic [npucs_pkg::VALUE_WIDTH-1:0] next_loop;
	logic [7:0]                        next_intr;
	logic                              reg_we;
	npucs_pkg::result_item_t           res;

	assign pop    = !q_status.empty && (!out_valid_q || !out_stall);
	assign pc_inc = (pc_q == PcMax) ? pc_q : pc_q + 1'b1;
	assign target = $signed({2'b00, pc_q}) - $signed({2'b00, op_item.offset}) +
	                (npucs_pkg::PC_WIDTH+2)'(1);
	assign reg_sum = shadow_q[op_item.reg_num] + op_item.arg;

	always_comb begin
		next_pc   = pc_inc;
		next_loop = loop_q;
		next_intr = intr_q;
		reg_we    = 1'b0;
		res       = '0;
		case (op_item.op)
			npucs_pkg::OP_SYNC: res.halted = 1'b1;
			npucs_pkg::OP_INTR: begin
				next_intr      = op_item.code;
				res.intr_valid = 1'b1;
			end
			npucs_pkg::OP_CONV: res.conv_start = 1'b1;
			npucs_pkg::OP_LOAD_COUNT: next_loop = op_item.arg;
			npucs_pkg::OP_LOOP: begin
				if (loop_q != '0) begin
					next_loop = loop_q - 1'b1;
					if (target < 0) begin
						res.fault = 1'b1;
						next_pc   = '0;
					end else if (target > $signed({2'b00, PcMax})) begin
						next_pc = PcMax;
					end else begin
						next_pc = target[npucs_pkg::PC_WIDTH-1:0];
					end
				end
			end
			npucs_pkg::OP_REG_WRITE: begin
				reg_we          = 1'b1;
				res.write_valid = 1'b1;
				res.write_index = op_item.reg_num;
				res.write_data  = op_item.arg;
			end
			npucs_pkg::OP_REG_INC: begin
				reg_we          = 1'b1;
				res.write_valid = 1'b1;
				res.write_index = op_item.reg_num;
				res.write_data  = reg_sum;
			end
			npucs_pkg::OP_REG_BAD: res.fault = 1'b1;
			npucs_pkg::OP_RESTART: next_pc = '0;
			default: ;
		endcase
		res.next_pc      = next_pc;
		res.intr_latched = next_intr;
		res.program_done = (next_pc >= plen_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			plen_q      <= '0;
			loop_q      <= '0;
			intr_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < npucs_pkg::NUM_REGS; i++) begin
				shadow_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				plen_q <= cfg_wdata;
			end
			if (pop) begin
				pc_q   <= next_pc;
				loop_q <= next_loop;
				intr_q <= next_intr;
				if (reg_we) begin
					shadow_q[op_item.reg_num] <= res.write_data;
				end
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ test/npu_command_sequencer_test.sv @@
// Self-checking testbench for npu_command_sequencer: directed and random command streams
// are checked against a cycle-free predictor of pc, loop counter, shadow registers and flags.
// Depends on npucs_pkg and the npu_command_sequencer RTL.
module npu_command_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 2;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [npucs_pkg::PC_WIDTH-1:0] cfg_wdata = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	npucs_pkg::cmd_item_t           in_data   = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	npucs_pkg::result_item_t        out_data;

	// Predicted sequencer state.
	logic [npucs_pkg::PC_WIDTH-1:0]    seq_pc        = '0;
	logic [npucs_pkg::VALUE_WIDTH-1:0] seq_loop_left = '0;
	logic [npucs_pkg::VALUE_WIDTH-1:0] seq_regs [npucs_pkg::NUM_REGS];
	logic [7:0]                        seq_intr      = '0;
	logic [npucs_pkg::PC_WIDTH-1:0]    seq_prog_len  = '0;

	npucs_pkg::result_item_t pending_results [$];
	npucs_pkg::result_item_t expected_head;
	int           mismatch_count = 0;
	int           send_idle_pct  = 0;
	int           recv_idle_pct  = 0;
	int           hold_len       = 0;
	int           hold_req       = 0;
	int           hold_seen      = 0;
	int           hold_left      = 0;

	npu_command_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #4 clk = ~clk;

	function automatic npucs_pkg::result_item_t next_sequencer_result(
			input npucs_pkg::cmd_item_t c);
		npucs_pkg::result_item_t r;
		int           nxt;
		int           target;
		int           reg_num;
		r = '0;
		nxt = (int'(seq_pc) >= npucs_pkg::PROGRAM_DEPTH) ? npucs_pkg::PROGRAM_DEPTH :
			int'(seq_pc) + 1;
		case (c.command)
			npucs_pkg::CMD_SYNC: r.halted = 1'b1;
			npucs_pkg::CMD_INTR: begin
				seq_intr = c.intr_code;
				r.intr_valid = 1'b1;
			end
			npucs_pkg::CMD_CONV: r.conv_start = 1'b1;
			npucs_pkg::CMD_LOOPCOUNT: seq_loop_left = c.loop_total;
			npucs_pkg::CMD_LOOP: begin
				if (seq_loop_left != 0) begin
					target = int'(seq_pc) - int'(c.jump_offset) + 1;
					seq_loop_left = seq_loop_left - 1'b1;
					if (target < 0) begin
						r.fault = 1'b1;
						nxt = 0;
					end else if (target > npucs_pkg::PROGRAM_DEPTH) begin
						nxt = npucs_pkg::PROGRAM_DEPTH;
					end else begin
						nxt = target;
					end
				end
			end
			npucs_pkg::CMD_REGWRITE, npucs_pkg::CMD_REGINC: begin
				reg_num = int'(c.reg_index) - npucs_pkg::REG_BASE;
				if (reg_num < 0 || reg_num >= npucs_pkg::NUM_REGS) begin
					r.fault = 1'b1;
				end else begin
					if (c.command == npucs_pkg::CMD_REGWRITE)
						seq_regs[reg_num] = c.reg_value;
					else
						seq_regs[reg_num] = seq_regs[reg_num] + c.reg_value;
					r.write_valid = 1'b1;
					r.write_index = npucs_pkg::REG_IDX_WIDTH'(reg_num);
					r.write_data  = seq_regs[reg_num];
				end
			end
			npucs_pkg::CMD_RESTART: nxt = 0;
			default: ;
		endcase
		seq_pc         = npucs_pkg::PC_WIDTH'(nxt);
		r.next_pc      = seq_pc;
		r.intr_latched = seq_intr;
		r.program_done = (seq_pc >= seq_prog_len);
		return r;
	endfunction

	function automatic npucs_pkg::cmd_item_t make_cmd(input logic [3:0] cmd, input int raw,
			input int value, input int total, input int offs, input int code);
		npucs_pkg::cmd_item_t c;
		c.command     = cmd;
		c.reg_index   = 6'(raw);
		c.reg_value   = 16'(value);
		c.loop_total  = 16'(total);
		c.jump_offset = 11'(offs);
		c.intr_code   = 8'(code);
		return c;
	endfunction

	// Mostly well-formed loop programs that stay near the start of the program,
	// with some fully random commands mixed in.
	function automatic npucs_pkg::cmd_item_t random_program_cmd(input int pc_bound);
		npucs_pkg::cmd_item_t c;
		int        pick;
		int        reach;
		c = make_cmd(npucs_pkg::CMD_NOP, $urandom_range(2, 33), $urandom_range(0, 65535),
			$urandom_range(0, 5), 0, $urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) begin
			c.command     = 4'($urandom_range(0, 15));
			c.reg_index   = 6'($urandom_range(0, 63));
			c.loop_total  = 16'($urandom_range(0, 65535));
			c.jump_offset = 11'($urandom_range(0, 2047));
		end else if (int'(seq_pc) > pc_bound) begin
			c.command = npucs_pkg::CMD_RESTART;
		end else if (pick < 12) begin
			c.command = npucs_pkg::CMD_LOOPCOUNT;
			if ($urandom_range(0, 19) == 0)
				c.loop_total = 16'($urandom_range(0, 65535));
		end else if (pick < 30) begin
			reach = int'(seq_pc) + 1;
			if (reach > 10)
				reach = 10;
			c.command     = npucs_pkg::CMD_LOOP;
			c.jump_offset = 11'($urandom_range(0, reach));
		end else if (pick < 66) begin
			c.command = (pick < 48) ? npucs_pkg::CMD_REGWRITE : npucs_pkg::CMD_REGINC;
			if ($urandom_range(0, 9) == 0)
				c.reg_index = 6'($urandom_range(0, 63));
		end else if (pick < 74) begin
			c.command = npucs_pkg::CMD_INTR;
		end else if (pick < 82) begin
			c.command = npucs_pkg::CMD_CONV;
		end else if (pick < 86) begin
			c.command = npucs_pkg::CMD_SYNC;
		end else if (pick < 93) begin
			c.command = npucs_pkg::CMD_NOP;
		end else begin
			c.command = npucs_pkg::CMD_RESTART;
		end
		return c;
	endfunction

	// Offers one command and returns at the edge where the transaction is accepted.
	task automatic send_cmd(input npucs_pkg::cmd_item_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(next_sequencer_result(c));
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_program_length(input logic [npucs_pkg::PC_WIDTH-1:0] len);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		seq_prog_len = len;
	endtask

	task automatic test_directed_commands();
		write_program_length(npucs_pkg::PC_WIDTH'(6));
		send_cmd(make_cmd(npucs_pkg::CMD_NOP, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_SYNC, 5, 16'h1234, 7, 3, 9));
		send_cmd(make_cmd(npucs_pkg::CMD_INTR, 0, 0, 0, 0, 8'hFF));
		send_cmd(make_cmd(npucs_pkg::CMD_INTR, 63, 16'hFFFF, 16'hFFFF, 2047, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_CONV, 2, 1, 1, 1, 1));
		// The increment after writing all ones wraps the register to zero.
		send_cmd(make_cmd(npucs_pkg::CMD_REGWRITE, 2, 16'hFFFF, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_REGINC, 2, 16'h0001, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_REGWRITE, 33, 16'hA5A5, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_REGINC, 33, 16'hFFFF, 0, 0, 0));
		// Raw indexes below the base or past the last register are rejected.
		send_cmd(make_cmd(npucs_pkg::CMD_REGWRITE, 0, 16'h5555, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_REGINC, 1, 16'h5555, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_REGWRITE, 34, 16'hAAAA, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_REGINC, 63, 16'hFFFF, 0, 0, 0));
		// A loop with an empty counter falls through.
		send_cmd(make_cmd(npucs_pkg::CMD_LOOP, 0, 0, 0, 5, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_LOOPCOUNT, 0, 0, 2, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_LOOP, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_LOOP, 0, 0, 0, 3, 0));
		// A jump back past the first command faults and clamps pc to zero.
		send_cmd(make_cmd(npucs_pkg::CMD_LOOPCOUNT, 0, 0, 16'hFFFF, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_LOOP, 0, 0, 0, 2047, 0));
		send_cmd(make_cmd(4'd9, 2, 16'h0F0F, 1, 1, 1));
		send_cmd(make_cmd(4'd15, 63, 16'hFFFF, 16'hFFFF, 2047, 8'hFF));
		send_cmd(make_cmd(npucs_pkg::CMD_RESTART, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_LOOPCOUNT, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_LOOP, 0, 0, 0, 1, 0));
	endtask

	// Runs pc up to the program depth and holds it there, then loops at the top.
	task automatic test_pc_saturation();
		npucs_pkg::cmd_item_t c;
		write_program_length(npucs_pkg::PC_WIDTH'(npucs_pkg::PROGRAM_DEPTH));
		send_cmd(make_cmd(npucs_pkg::CMD_RESTART, 0, 0, 0, 0, 0));
		repeat (npucs_pkg::PROGRAM_DEPTH + 6) begin
			do
				c.command = 4'($urandom_range(0, 15));
			while (c.command == npucs_pkg::CMD_LOOP || c.command == npucs_pkg::CMD_RESTART);
			c.reg_index   = 6'($urandom_range(0, 63));
			c.reg_value   = 16'($urandom_range(0, 65535));
			c.loop_total  = 16'($urandom_range(0, 65535));
			c.jump_offset = 11'($urandom_range(0, 2047));
			c.intr_code   = 8'($urandom_range(0, 255));
			send_cmd(c);
		end
		send_cmd(make_cmd(npucs_pkg::CMD_LOOPCOUNT, 0, 0, 3, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_LOOP, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_LOOP, 0, 0, 0, 1, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_LOOP, 0, 0, 0, npucs_pkg::PROGRAM_DEPTH, 0));
		send_cmd(make_cmd(npucs_pkg::CMD_RESTART, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_programs(input int count, input int len);
		write_program_length(npucs_pkg::PC_WIDTH'(len));
		repeat (count) send_cmd(random_program_cmd(len + 12));
	endtask

	// The receiver holds off long enough for the queue to fill and stall the fetch side.
	task automatic test_backpressure();
		write_program_length(npucs_pkg::PC_WIDTH'($urandom_range(4, 30)));
		hold_len <= 200;
		hold_req <= hold_req + 1;
		repeat (40) send_cmd(random_program_cmd(40));
		wait_drain();
		hold_len <= 60;
		hold_req <= hold_req + 1;
		repeat (20) send_cmd(random_program_cmd(40));
	endtask

	// Result side: checks every accepted transaction and drives the stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result with nothing outstanding: %p", out_data);
			end else begin
				expected_head = pending_results.pop_front();
				if (out_data !== expected_head) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp pc=%0d wv=%b wi=%0d wd=%h",
							expected_head.next_pc, expected_head.write_valid,
							expected_head.write_index, expected_head.write_data,
							" conv=%b iv=%b il=%h halt=%b done=%b fault=%b",
							expected_head.conv_start, expected_head.intr_valid,
							expected_head.intr_latched, expected_head.halted,
							expected_head.program_done, expected_head.fault,
							" | got pc=%0d wv=%b wi=%0d wd=%h",
							out_data.next_pc, out_data.write_valid, out_data.write_index,
							out_data.write_data,
							" conv=%b iv=%b il=%h halt=%b done=%b fault=%b",
							out_data.conv_start, out_data.intr_valid,
							out_data.intr_latched, out_data.halted, out_data.program_done,
							out_data.fault);
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= hold_len;
			out_stall <= 1'b1;
		end else begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1) || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	initial begin
		foreach (seq_regs[i])
			seq_regs[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 35;
		recv_idle_pct = 66;
		test_directed_commands();
		test_random_programs(200, $urandom_range(1, 40));
		send_idle_pct = 66;
		recv_idle_pct = 35;
		test_pc_saturation();
		test_random_programs(120, 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_programs(100, $urandom_range(8, 30));
		wait_drain();
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
